### sv/complex_arithmetic_unit_defines.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define CAU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex arithmetic unit check failed");
// next-cycle implication, checked outside reset
`define CAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex arithmetic unit check failed");
`else
`define CAU_ASSERT_IMPL(label, ante, cons)
`define CAU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int MAG_W      = 2 * DATA_WIDTH;
  localparam int SUM_W      = 2 * DATA_WIDTH + 1;
  localparam int REM_W      = 3 * DATA_WIDTH;
  localparam int DIV_LAT    = DATA_WIDTH + 1;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef struct packed {
    op_t                           op;
    logic signed [DATA_WIDTH-1:0]  a_re;
    logic signed [DATA_WIDTH-1:0]  a_im;
    logic signed [DATA_WIDTH-1:0]  b_re;
    logic signed [DATA_WIDTH-1:0]  b_im;
    logic                          dbz;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } qhead_t;
endpackage
`default_nettype wire

### sv/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply or divide two complex Q8.8 operands.
// Takes one word per cycle and gives one result word per cycle while the output is
// not stalled. Each word passes through the two product stages, then the
// one-bit-per-stage quotient pipeline or the delay line beside it, then the output
// register. A four-word input queue lets the input keep flowing while the output is
// stalled, until the queue is full. Results saturate and raise overflow; a zero
// divisor gives zero with divide_by_zero set.
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            in_op,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]      out_res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0]      out_res_im,
  output logic                                       out_divide_by_zero,
  output logic                                       out_overflow
);
  import cau_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MAXV = DATA_WIDTH'((64'd1 << (DATA_WIDTH-1)) - 64'd1);
  localparam logic [DATA_WIDTH-1:0] MINV = DATA_WIDTH'(64'd1 << (DATA_WIDTH-1));

  qhead_t head;
  logic   pop;
  logic   out_zero;
  logic   out_at_lim;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .pop      (pop),
    .head     (head)
  );

  cau_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_res_re         (out_res_re),
    .out_res_im         (out_res_im),
    .out_divide_by_zero (out_divide_by_zero),
    .out_overflow       (out_overflow)
  );

  // result shape seen by the checks below
  assign out_zero   = (out_res_re == '0) && (out_res_im == '0) && !out_overflow;
  assign out_at_lim = (out_res_re == MAXV) || (out_res_re == MINV) ||
                      (out_res_im == MAXV) || (out_res_im == MINV);

  // a zero divisor gives a clean zero result
  `CAU_ASSERT_IMPL(a_dbz_zero, out_valid && out_divide_by_zero, out_zero)
  // overflow leaves at least one part at a range limit
  `CAU_ASSERT_IMPL(a_ovf_clip, out_valid && out_overflow, out_at_lim)
  // a held result keeps its value
  `CAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_res_re) && $stable(out_res_im))
endmodule
`default_nettype wire

### sv/cau_front.sv
// Front end: accepts words, flags a zero divisor and queues them for the back end.
`default_nettype none
module cau_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_op,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
  input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
  input  wire logic                             pop,
  output cau_pkg::qhead_t                       head
);
  import cau_pkg::*;

  item_t          q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           push, pop_ok;
  item_t          cls;

  // classify the incoming word
  always_comb begin
    cls.op   = op_t'(in_op);
    cls.a_re = in_a_re;
    cls.a_im = in_a_im;
    cls.b_re = in_b_re;
    cls.b_im = in_b_im;
    cls.dbz  = (op_t'(in_op) == OP_DIV) && (in_b_re == '0) && (in_b_im == '0);
  end

  assign in_stall = (cnt_r == (QAW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop_ok   = pop && (cnt_r != '0);
  assign head.vld  = (cnt_r != '0);
  assign head.item = q_r[rp_r];

  // store the word
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)   wp_r <= wp_r + 1'b1;
      if (pop_ok) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop_ok);
    end
  end
endmodule
`default_nettype wire

### sv/cau_div.sv
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit a stage.
`default_nettype none
module cau_div (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [cau_pkg::MAG_W-1:0]       num,
  input  wire logic [cau_pkg::MAG_W-1:0]       den,
  output logic [cau_pkg::DATA_WIDTH-1:0]       quo,
  output logic                                 big
);
  import cau_pkg::*;

  logic [REM_W-1:0]      rem_r [DATA_WIDTH+1];
  logic [REM_W-1:0]      den_r [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] q_r   [DATA_WIDTH+1];
  logic                  big_r [DATA_WIDTH+1];

  // scale the dividend and detect a quotient past the result range
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM_W'(num) << FRAC_BITS;
      den_r[0] <= REM_W'(den);
      q_r[0]   <= '0;
      big_r[0] <= (REM_W'(num) << FRAC_BITS) >= (REM_W'(den) << DATA_WIDTH);
    end
  end

  // one compare and subtract per stage, most significant bit first
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
    localparam int BIT = DATA_WIDTH - 1 - k;
    logic [REM_W-1:0] d;
    logic             ge;
    assign d  = den_r[k] << BIT;
    assign ge = rem_r[k] >= d;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? rem_r[k] - d : rem_r[k];
        den_r[k+1] <= den_r[k];
        q_r[k+1]   <= q_r[k] | (DATA_WIDTH'(ge) << BIT);
        big_r[k+1] <= big_r[k];
      end
    end
  end

  assign quo = q_r[DATA_WIDTH];
  assign big = big_r[DATA_WIDTH];
endmodule
`default_nettype wire

### sv/cau_back.sv
// Back end: products, sums, quotient pipeline, saturation and the output register.
`default_nettype none
module cau_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cau_pkg::qhead_t                  head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_im,
  output logic                                  out_divide_by_zero,
  output logic                                  out_overflow
);
  import cau_pkg::*;

  typedef struct packed {
    op_t              op;
    logic             dbz;
    logic             neg_re;
    logic             neg_im;
    logic [MAG_W-1:0] mag_re;
    logic [MAG_W-1:0] mag_im;
  } side_t;

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (DATA_WIDTH-1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (DATA_WIDTH-1));
  localparam logic [MAG_W-1:0] BIG_Q   = MAG_W'(64'd1 << DATA_WIDTH);

  logic en;
  logic out_valid_r;

  // stage 1 registers
  logic                    s1_vld_r;
  op_t                     s1_op_r;
  logic                    s1_dbz_r;
  logic signed [MAG_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic        [MAG_W-1:0] sq_r_r, sq_i_r;
  logic signed [SUM_W-1:0] as_re_r, as_im_r;

  // stage 2
  logic signed [SUM_W-1:0] s_re, s_im;
  logic        [SUM_W-1:0] abs_re, abs_im;
  side_t                   s2;
  logic                    s2_vld_r;
  side_t                   s2_r;
  logic        [MAG_W-1:0] den_r;

  // delay line alongside the divider
  logic                    sd_vld_r [DIV_LAT];
  side_t                   sd_r     [DIV_LAT];
  logic [DATA_WIDTH-1:0]   q_re, q_im;
  logic                    big_re, big_im;

  // final stage
  side_t                   fin;
  logic [MAG_W-1:0]        m_re, m_im, lim_re, lim_im, c_re, c_im;
  logic                    ov_re, ov_im;
  logic [DATA_WIDTH-1:0]   r_re, r_im;
  logic                    ovf;

  assign en  = !out_valid_r || !out_stall;
  assign pop = en && head.vld;

  // multiply and add or subtract the operands
  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r  <= head.item.op;
      s1_dbz_r <= head.item.dbz;
      p_rr_r   <= MAG_W'(head.item.a_re) * MAG_W'(head.item.b_re);
      p_ii_r   <= MAG_W'(head.item.a_im) * MAG_W'(head.item.b_im);
      p_ri_r   <= MAG_W'(head.item.a_re) * MAG_W'(head.item.b_im);
      p_ir_r   <= MAG_W'(head.item.a_im) * MAG_W'(head.item.b_re);
      sq_r_r   <= MAG_W'(head.item.b_re * head.item.b_re);
      sq_i_r   <= MAG_W'(head.item.b_im * head.item.b_im);
      if (head.item.op == OP_SUB) begin
        as_re_r <= SUM_W'(head.item.a_re) - SUM_W'(head.item.b_re);
        as_im_r <= SUM_W'(head.item.a_im) - SUM_W'(head.item.b_im);
      end else begin
        as_re_r <= SUM_W'(head.item.a_re) + SUM_W'(head.item.b_re);
        as_im_r <= SUM_W'(head.item.a_im) + SUM_W'(head.item.b_im);
      end
    end
  end

  // combine products and split into sign and magnitude
  always_comb begin
    unique case (s1_op_r)
      OP_ADD, OP_SUB: begin
        s_re = as_re_r;
        s_im = as_im_r;
      end
      OP_MUL: begin
        s_re = SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
        s_im = SUM_W'(p_ri_r) + SUM_W'(p_ir_r);
      end
      OP_DIV: begin
        s_re = SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
        s_im = SUM_W'(p_ir_r) - SUM_W'(p_ri_r);
      end
    endcase
    abs_re    = s_re[SUM_W-1] ? -s_re : s_re;
    abs_im    = s_im[SUM_W-1] ? -s_im : s_im;
    s2.op     = s1_op_r;
    s2.dbz    = s1_dbz_r;
    s2.neg_re = s_re[SUM_W-1];
    s2.neg_im = s_im[SUM_W-1];
    if (s1_op_r == OP_MUL) begin
      s2.mag_re = abs_re[MAG_W-1:0] >> FRAC_BITS;
      s2.mag_im = abs_im[MAG_W-1:0] >> FRAC_BITS;
    end else begin
      s2.mag_re = abs_re[MAG_W-1:0];
      s2.mag_im = abs_im[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r  <= s2;
      den_r <= sq_r_r + sq_i_r;
    end
  end

  cau_div u_div_re (
    .clk (clk), .en (en), .num (s2_r.mag_re), .den (den_r), .quo (q_re), .big (big_re)
  );
  cau_div u_div_im (
    .clk (clk), .en (en), .num (s2_r.mag_im), .den (den_r), .quo (q_im), .big (big_im)
  );

  // carry the rest of the word beside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= s2_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        sd_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      s1_vld_r    <= head.vld;
      s2_vld_r    <= s1_vld_r;
      sd_vld_r[0] <= s2_vld_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_vld_r[i] <= sd_vld_r[i-1];
      end
    end
  end

  // pick the magnitude and saturate
  always_comb begin
    fin = sd_r[DIV_LAT-1];
    if (fin.op == OP_DIV) begin
      m_re = big_re ? BIG_Q : MAG_W'(q_re);
      m_im = big_im ? BIG_Q : MAG_W'(q_im);
    end else begin
      m_re = fin.mag_re;
      m_im = fin.mag_im;
    end
    lim_re = fin.neg_re ? NEG_LIM : POS_LIM;
    lim_im = fin.neg_im ? NEG_LIM : POS_LIM;
    ov_re  = m_re > lim_re;
    ov_im  = m_im > lim_im;
    c_re   = ov_re ? lim_re : m_re;
    c_im   = ov_im ? lim_im : m_im;
    r_re   = fin.neg_re ? -c_re[DATA_WIDTH-1:0] : c_re[DATA_WIDTH-1:0];
    r_im   = fin.neg_im ? -c_im[DATA_WIDTH-1:0] : c_im[DATA_WIDTH-1:0];
    ovf    = ov_re || ov_im;
    if (fin.dbz) begin
      r_re = '0;
      r_im = '0;
      ovf  = 1'b0;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (en) begin
      out_res_re         <= r_re;
      out_res_im         <= r_im;
      out_divide_by_zero <= fin.dbz;
      out_overflow       <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sd_vld_r[DIV_LAT-1];
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

### tb/complex_arithmetic_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit: directed table plus random words.
`default_nettype none
module complex_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int DW         = DATA_WIDTH;
  localparam int N_RANDOM   = 1700;
  localparam int N_QUIET    = 200;
  localparam int WATCH_MAX  = 4000;
  localparam int DRAIN_WAIT = 40;
  localparam longint POS_LIM = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint NEG_LIM = -(64'sd1 <<< (DW - 1));

  typedef logic signed [DW-1:0] part_t;

  typedef struct {
    part_t re;
    part_t im;
    logic  dbz;
    logic  ovf;
  } cplx_res_t;

  typedef struct {
    logic      typed;
    op_t       op;
    part_t     a_re;
    part_t     a_im;
    part_t     b_re;
    part_t     b_im;
    cplx_res_t want;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  op_t   in_op = OP_ADD;
  part_t in_a_re = '0;
  part_t in_a_im = '0;
  part_t in_b_re = '0;
  part_t in_b_im = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  part_t out_res_re;
  part_t out_res_im;
  logic  out_divide_by_zero;
  logic  out_overflow;

  cplx_res_t pending_results[$];
  int  err_cnt = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  op_cnt[4] = '{0, 0, 0, 0};
  int  idle_cnt = 0;
  bit  quiet = 1'b0;

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_divide_by_zero(out_divide_by_zero), .out_overflow(out_overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Clip one exact part to the signed range and note saturation
  function automatic part_t clip_part(input longint v, inout logic ovf);
    if (v > POS_LIM) begin
      ovf = 1'b1;
      return part_t'(POS_LIM);
    end
    if (v < NEG_LIM) begin
      ovf = 1'b1;
      return part_t'(NEG_LIM);
    end
    return part_t'(v);
  endfunction

  // Exact complex arithmetic, truncation toward zero, then saturation
  function automatic cplx_res_t complex_result(input op_t op, input part_t ar, ai, br, bi);
    cplx_res_t r;
    longint x_re, x_im, den, m_re, m_im;
    r.dbz = 1'b0;
    r.ovf = 1'b0;
    x_re = 0;
    x_im = 0;
    case (op)
      OP_ADD: begin
        x_re = longint'(ar) + longint'(br);
        x_im = longint'(ai) + longint'(bi);
      end
      OP_SUB: begin
        x_re = longint'(ar) - longint'(br);
        x_im = longint'(ai) - longint'(bi);
      end
      OP_MUL: begin
        x_re = longint'(ar) * br - longint'(ai) * bi;
        x_im = longint'(ar) * bi + longint'(ai) * br;
        m_re = (x_re < 0 ? -x_re : x_re) >>> FRAC_BITS;
        m_im = (x_im < 0 ? -x_im : x_im) >>> FRAC_BITS;
        x_re = x_re < 0 ? -m_re : m_re;
        x_im = x_im < 0 ? -m_im : m_im;
      end
      default: begin
        den = longint'(br) * br + longint'(bi) * bi;
        if (den == 0) begin
          r.dbz = 1'b1;
        end else begin
          x_re = longint'(ar) * br + longint'(ai) * bi;
          x_im = longint'(ai) * br - longint'(ar) * bi;
          m_re = ((x_re < 0 ? -x_re : x_re) <<< FRAC_BITS) / den;
          m_im = ((x_im < 0 ? -x_im : x_im) <<< FRAC_BITS) / den;
          x_re = x_re < 0 ? -m_re : m_re;
          x_im = x_im < 0 ? -m_im : m_im;
        end
      end
    endcase
    r.re = clip_part(x_re, r.ovf);
    r.im = clip_part(x_im, r.ovf);
    return r;
  endfunction

  // Present one word, hold it until accepted, then record its expectation
  task automatic send_word(input op_t op, input part_t ar, ai, br, bi, input cplx_res_t want);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_a_re  <= ar;
    in_a_im  <= ai;
    in_b_re  <= br;
    in_b_im  <= bi;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(want);
    words_in++;
    op_cnt[op]++;
  endtask

  // Random operand: full range half the time, else small values and corners
  function automatic part_t rand_part();
    case ($urandom_range(0, 9))
      0: return part_t'(NEG_LIM);
      1: return part_t'(POS_LIM);
      2: return '0;
      3, 4: return part_t'($signed($urandom_range(0, 1023)) - 512);
      default: return part_t'($urandom());
    endcase
  endfunction

  // Receiver: stall in random bursts until the quiet tail
  initial begin
    int burst;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    cplx_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: re=%0d im=%0d", out_res_re, out_res_im);
        err_cnt++;
      end else begin
        w = pending_results.pop_front();
        if (out_res_re !== w.re) begin
          $error("res_re: expected %0d, got %0d", w.re, out_res_re);
          err_cnt++;
        end
        if (out_res_im !== w.im) begin
          $error("res_im: expected %0d, got %0d", w.im, out_res_im);
          err_cnt++;
        end
        if (out_divide_by_zero !== w.dbz) begin
          $error("divide_by_zero: expected %0b, got %0b", w.dbz, out_divide_by_zero);
          err_cnt++;
        end
        if (out_overflow !== w.ovf) begin
          $error("overflow: expected %0b, got %0b", w.ovf, out_overflow);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCH_MAX) begin
      $display("complex_arithmetic_unit_tb: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Stimulus: reset, directed table, random words, drain
  initial begin
    dir_row_t rows[] = '{
      '{1'b1, OP_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1}},
      '{1'b1, OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        '{16'sh8000, 16'sh8000, 1'b0, 1'b1}},
      '{1'b1, OP_ADD, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0}},
      '{1'b1, OP_SUB, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
        '{16'sh8000, 16'sh7FFF, 1'b0, 1'b1}},
      '{1'b1, OP_SUB, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0}},
      '{1'b1, OP_DIV, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000,
        '{16'sh0000, 16'sh0000, 1'b1, 1'b0}},
      '{1'b1, OP_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        '{16'sh0000, 16'sh0000, 1'b1, 1'b0}},
      '{1'b1, OP_MUL, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000,
        '{16'sh0100, 16'sh0000, 1'b0, 1'b0}},
      '{1'b0, OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, '{0, 0, 0, 0}},
      '{1'b0, OP_MUL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, '{0, 0, 0, 0}},
      '{1'b0, OP_MUL, 16'shFFFF, 16'sh0001, 16'sh0001, 16'sh0001, '{0, 0, 0, 0}},
      '{1'b0, OP_MUL, 16'sh0180, 16'shFE80, 16'sh0240, 16'sh0010, '{0, 0, 0, 0}},
      '{1'b0, OP_DIV, 16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh0000, '{0, 0, 0, 0}},
      '{1'b0, OP_DIV, 16'sh8000, 16'sh0000, 16'sh0000, 16'shFFFF, '{0, 0, 0, 0}},
      '{1'b0, OP_DIV, 16'sh0100, 16'sh0000, 16'sh7FFF, 16'sh8000, '{0, 0, 0, 0}},
      '{1'b0, OP_DIV, 16'shFF00, 16'sh0300, 16'sh0100, 16'sh0100, '{0, 0, 0, 0}},
      '{1'b0, OP_DIV, 16'sh0001, 16'shFFFF, 16'sh8000, 16'sh8000, '{0, 0, 0, 0}},
      '{1'b0, OP_DIV, 16'sh0200, 16'sh0000, 16'sh0000, 16'sh0080, '{0, 0, 0, 0}}
    };
    cplx_res_t want;
    op_t   op;
    part_t ar, ai, br, bi;
    int    wait_cnt;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed rows carry their own expectation
    foreach (rows[i]) begin
      want = rows[i].typed ? rows[i].want
           : complex_result(rows[i].op, rows[i].a_re, rows[i].a_im, rows[i].b_re, rows[i].b_im);
      send_word(rows[i].op, rows[i].a_re, rows[i].a_im, rows[i].b_re, rows[i].b_im, want);
    end

    // Random words; the tail runs without idling
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      op = op_t'($urandom_range(0, 3));
      ar = rand_part();
      ai = rand_part();
      br = rand_part();
      bi = rand_part();
      if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_word(op, ar, ai, br, bi, complex_result(op, ar, ai, br, bi));
    end
    in_valid <= 1'b0;

    // Drain, then settle past the pipeline latency
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < WATCH_MAX) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      err_cnt++;
    end

    $display("covered %0d words in, %0d out: add %0d, sub %0d, mul %0d, div %0d",
             words_in, words_out, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3]);
    $display("with saturation corners, zero divisors and random stalls on both sides");
    if (err_cnt == 0) begin
      $display("complex_arithmetic_unit_tb: clean");
    end else begin
      $display("complex_arithmetic_unit_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
